FILE: rtl/core/copg_pkg.sv
// ----------------------------------------------------------------------------
// copg_pkg: shared types and constants of the circle outline point generator
// Field widths, register indexes, configuration and job records.
// ----------------------------------------------------------------------------
package copg_pkg;

  localparam int unsigned CoordW     = 8;
  localparam int unsigned RadiusW    = 7;
  localparam int unsigned SqW        = 14;
  localparam int unsigned ResW       = 15;
  localparam int unsigned IterN      = 8;
  localparam int unsigned IterW      = 3;
  localparam int unsigned CfgAddrW   = 2;
  localparam int unsigned CfgDataW   = 8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgAddrW-1:0] RegCenterX = 2'd0;
  localparam logic [CfgAddrW-1:0] RegCenterY = 2'd1;
  localparam logic [CfgAddrW-1:0] RegRadius  = 2'd2;

  localparam logic [RadiusW-1:0] RadiusMax   = 7'd127;
  localparam logic [RadiusW-1:0] RadiusCap   = 7'd126;
  localparam logic [CoordW-1:0]  CenterReset = 8'd128;
  localparam logic [ResW-1:0]    SqrtTopBit  = 15'h4000;

  typedef struct packed {
    logic [CoordW-1:0]  center_x;
    logic [CoordW-1:0]  center_y;
    logic [RadiusW-1:0] radius;
    logic [SqW-1:0]     radius_sq;
  } cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic              lower;
    logic              dwell;
    logic              last;
  } job_t;

endpackage

FILE: rtl/core/copg_front.sv
// ----------------------------------------------------------------------------
// copg_front: configuration and sequence walker
// Holds the registers, walks the x offset over both halves and queues jobs.
// ----------------------------------------------------------------------------
module copg_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [copg_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [copg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           restart_i,
  input  logic                           full_i,
  output logic                           push_o,
  output copg_pkg::job_t                 job_o,
  output copg_pkg::cfg_t                 cfg_o
);

  copg_pkg::cfg_t                  cfg_q;
  logic [copg_pkg::CoordW-1:0]     offset_q, offset_d;
  logic                            lower_q, lower_d;
  logic [copg_pkg::CoordW-1:0]     r8, neg_r, x;
  logic                            lo;
  logic [copg_pkg::RadiusW-1:0]    rad_new;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign cfg_o      = cfg_q;

  assign r8      = {1'b0, cfg_q.radius};
  assign neg_r   = -r8;
  assign x       = restart_i ? neg_r : offset_q;
  assign lo      = restart_i ? 1'b0 : lower_q;
  assign rad_new = (cfg_wdata_i[copg_pkg::RadiusW-1:0] == copg_pkg::RadiusMax) ?
                   copg_pkg::RadiusCap : cfg_wdata_i[copg_pkg::RadiusW-1:0];

  always_comb begin
    offset_d    = offset_q;
    lower_d     = lower_q;
    job_o.x     = x;
    job_o.lower = lo;
    job_o.dwell = (x == neg_r);
    job_o.last  = 1'b0;
    if (!lo) begin
      job_o.last = (cfg_q.radius == '0);
      if ($signed(x) < $signed(r8)) begin
        offset_d = x + 8'd1;
        lower_d  = 1'b0;
      end else if (cfg_q.radius == '0) begin
        offset_d = neg_r;
        lower_d  = 1'b0;
      end else begin
        offset_d = r8 - 8'd1;
        lower_d  = 1'b1;
      end
    end else begin
      job_o.last = (x == neg_r);
      if ($signed(x) > $signed(neg_r)) begin
        offset_d = x - 8'd1;
        lower_d  = 1'b1;
      end else begin
        offset_d = neg_r;
        lower_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x  <= copg_pkg::CenterReset;
      cfg_q.center_y  <= copg_pkg::CenterReset;
      cfg_q.radius    <= '0;
      cfg_q.radius_sq <= '0;
      offset_q        <= '0;
      lower_q         <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        copg_pkg::RegCenterX: cfg_q.center_x <= cfg_wdata_i;
        copg_pkg::RegCenterY: cfg_q.center_y <= cfg_wdata_i;
        copg_pkg::RegRadius: begin
          cfg_q.radius    <= rad_new;
          cfg_q.radius_sq <= copg_pkg::SqW'(rad_new) * copg_pkg::SqW'(rad_new);
          offset_q        <= -{1'b0, rad_new};
          lower_q         <= 1'b0;
        end
        default: ;
      endcase
    end else if (push_o) begin
      offset_q <= offset_d;
      lower_q  <= lower_d;
    end
  end

endmodule

FILE: rtl/core/copg_queue.sv
// ----------------------------------------------------------------------------
// copg_queue: job queue between walker and square root unit
// Small circular buffer of job records with full and empty flags.
// ----------------------------------------------------------------------------
module copg_queue #(
  parameter int unsigned Depth = copg_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  copg_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output copg_pkg::job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  copg_pkg::job_t     mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/copg_back.sv
// ----------------------------------------------------------------------------
// copg_back: square root unit and output register
// Runs a digit-by-digit integer square root, two bits per cycle, and forms
// the DAC codes of the point.
// ----------------------------------------------------------------------------
module copg_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  copg_pkg::cfg_t               cfg_i,
  input  logic                         empty_i,
  input  copg_pkg::job_t               job_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [copg_pkg::CoordW-1:0]  point_x_o,
  output logic [copg_pkg::CoordW-1:0]  point_y_o,
  output logic                         dwell_o,
  output logic                         last_point_o
);

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDone
  } state_e;

  state_e                          state_q;
  copg_pkg::job_t                  job_q;
  logic [copg_pkg::IterW-1:0]      cnt_q;
  logic [copg_pkg::SqW-1:0]        v_q, v_d, v_load;
  logic [copg_pkg::ResW-1:0]       res_q, res_d, bit_w;
  logic [copg_pkg::ResW:0]         trial;
  logic [copg_pkg::RadiusW-1:0]    ax;
  logic [copg_pkg::CoordW-1:0]     neg_x, y8, sq8;
  logic                            out_free, load_out;
  logic                            out_valid_q;
  logic [copg_pkg::CoordW-1:0]     point_x_q, point_y_q;
  logic                            dwell_q, last_q;

  assign pop_o    = (state_q == StIdle) && !empty_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == StDone) && out_free;

  assign neg_x  = -job_i.x;
  assign ax     = job_i.x[copg_pkg::CoordW-1] ? neg_x[copg_pkg::RadiusW-1:0]
                                              : job_i.x[copg_pkg::RadiusW-1:0];
  assign v_load = cfg_i.radius_sq - copg_pkg::SqW'(ax) * copg_pkg::SqW'(ax);

  assign bit_w = copg_pkg::SqrtTopBit >> {cnt_q, 1'b0};
  assign trial = {1'b0, res_q} + {1'b0, bit_w};

  always_comb begin
    v_d   = v_q;
    res_d = res_q >> 1;
    if ({2'b00, v_q} >= trial) begin
      v_d   = v_q - trial[copg_pkg::SqW-1:0];
      res_d = (res_q >> 1) + bit_w;
    end
  end

  assign sq8 = {1'b0, res_q[copg_pkg::RadiusW-1:0]};
  assign y8  = job_q.lower ? -sq8 : sq8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (pop_o) begin
            state_q <= StRun;
            cnt_q   <= '0;
          end
        end
        StRun: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == copg_pkg::IterW'(copg_pkg::IterN - 1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      v_q   <= v_load;
      res_q <= '0;
    end else if (state_q == StRun) begin
      v_q   <= v_d;
      res_q <= res_d;
    end
    if (load_out) begin
      point_x_q <= cfg_i.center_x + job_q.x;
      point_y_q <= cfg_i.center_y + y8;
      dwell_q   <= job_q.dwell;
      last_q    <= job_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign point_x_o    = point_x_q;
  assign point_y_o    = point_y_q;
  assign dwell_o      = dwell_q;
  assign last_point_o = last_q;

endmodule

FILE: rtl/core/circle_outline_point_generator_top.sv
// ----------------------------------------------------------------------------
// circle_outline_point_generator_top: circle outline point generator
// Emits one point of a circle outline per input beat, in 8-bit DAC codes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  cfg     | in        | cfg_we_i                | cfg_addr_i, cfg_wdata_i
//  in      | in        | in_valid_i / in_stall_o | restart_i
//  out     | out       | out_valid_o/out_stall_i | point_x_o, point_y_o, dwell_o,
//          |           |                         | last_point_o
//
//  An output beat follows its input beat through the queue, a pop of the
//  queue, eight square root iterations of two bits each, the output load
//  and the output register.
//  The square root unit sets the sustained rate: it pops a new job only once the last point is loaded.
//  Reset clears the walker to the first point, the queue and the output.
//  The walker queues up to QueueDepth beats ahead while the output stalls.
module circle_outline_point_generator_top #(
  parameter int unsigned QueueDepth = copg_pkg::QueueDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [copg_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [copg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [copg_pkg::CoordW-1:0]    point_x_o,
  output logic [copg_pkg::CoordW-1:0]    point_y_o,
  output logic                           dwell_o,
  output logic                           last_point_o
);

  copg_pkg::cfg_t cfg;
  copg_pkg::job_t push_job, pop_job;
  logic           push, full, pop, empty;

  copg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job),
    .cfg_o       (cfg)
  );

  copg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (pop_job)
  );

  copg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .empty_i      (empty),
    .job_i        (pop_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .dwell_o      (dwell_o),
    .last_point_o (last_point_o)
  );

endmodule

FILE: rtl/core/copg_checker.sv
// ----------------------------------------------------------------------------
// copg_checker: port-level checks of the circle outline point generator
// Watches the top level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module copg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [copg_pkg::CoordW-1:0]   point_x_o,
  input logic [copg_pkg::CoordW-1:0]   point_y_o,
  input logic                          dwell_o,
  input logic                          last_point_o
);

  // hold a stalled output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(point_x_o) &&
      $stable(point_y_o) && $stable(dwell_o) && $stable(last_point_o))
    else $error("stalled output beat changed");

  // the closing point always sits at x equal to minus radius
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_point_o |-> dwell_o)
    else $error("last point without dwell");

  // the queue fills only through an accepted input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an input beat");

endmodule

bind circle_outline_point_generator_top copg_checker u_copg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .point_x_o    (point_x_o),
  .point_y_o    (point_y_o),
  .dwell_o      (dwell_o),
  .last_point_o (last_point_o)
);
